[hdl/typed_record_frame_unpacker_defines.svh]
// Assertion macros shared by the frame unpacker modules.
// Each macro expects the enclosing module to have aclk and aresetn.
`ifndef TYPED_RECORD_FRAME_UNPACKER_DEFINES_SVH
`define TYPED_RECORD_FRAME_UNPACKER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TRFU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TRFU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/trfu_pkg.sv]
`default_nettype none

package trfu_pkg;

    localparam logic [7:0] FRAME_LENGTH_RESET = 8'd100;
    localparam logic [7:0] FRAME_LENGTH_MIN   = 8'd2;
    localparam logic [7:0] TAG_MAX            = 8'd8;
    localparam int         FIFO_DEPTH         = 2;

    typedef enum logic [3:0] {
        PH_COUNT   = 4'b0001,
        PH_TAG     = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_SKIP    = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_TAG   = 2'd1,
        STATUS_TRUNCATED = 2'd2
    } status_t;

    // One classified byte handed from the parser to the assembler.
    typedef struct packed {
        logic       clear;   // start a new record: zero the accumulator
        logic       write;   // merge data into the accumulator
        logic [7:0] data;
        logic [2:0] idx;     // byte lane of data within the 64-bit word
        logic       emit;    // this byte produces a result
        logic [3:0] tag;
        status_t    status;
        logic       last;
    } op_t;

    // Payload bytes carried by each tag; invalid tags carry none.
    function automatic logic [3:0] payload_size(input logic [3:0] tag);
        logic [3:0] size;
        case (tag)
            4'd1:    size = 4'd8;
            4'd2:    size = 4'd4;
            4'd3:    size = 4'd4;
            4'd4:    size = 4'd4;
            4'd5:    size = 4'd2;
            4'd6:    size = 4'd2;
            4'd7:    size = 4'd1;
            4'd8:    size = 4'd1;
            default: size = 4'd0;
        endcase
        return size;
    endfunction

endpackage

`default_nettype wire

[hdl/trfu_front.sv]
`default_nettype none

`include "typed_record_frame_unpacker_defines.svh"

module trfu_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic [7:0]    cfg_wr_data,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [7:0]    s_rx_byte,
    input  wire logic          q_full,
    output logic               q_push,
    output trfu_pkg::op_t      q_op
);

    logic [7:0]       frame_length_reg;
    trfu_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       pos_reg, pos_next;
    logic [7:0]       expected_reg, expected_next;
    logic [7:0]       seen_reg, seen_next;
    logic [3:0]       tag_reg, tag_next;
    logic [3:0]       remaining_reg, remaining_next;
    logic [2:0]       idx_reg, idx_next;

    logic [7:0]       len;
    logic             last;
    logic             accept;
    logic             tag_ok;
    logic [7:0]       seen_inc;
    trfu_pkg::op_t    op;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    assign len      = (frame_length_reg < trfu_pkg::FRAME_LENGTH_MIN) ?
                      trfu_pkg::FRAME_LENGTH_MIN : frame_length_reg;
    assign last     = ({1'b0, pos_reg} + 9'd1) >= {1'b0, len};
    assign tag_ok   = (s_rx_byte != 8'd0) && (s_rx_byte <= trfu_pkg::TAG_MAX);
    assign seen_inc = seen_reg + 8'd1;

    always_comb begin
        phase_next     = phase_reg;
        expected_next  = expected_reg;
        seen_next      = seen_reg;
        tag_next       = tag_reg;
        remaining_next = remaining_reg;
        idx_next       = idx_reg;
        op             = '0;
        op.status      = trfu_pkg::STATUS_OK;
        op.data        = s_rx_byte;
        op.idx         = idx_reg;
        op.tag         = tag_reg;

        case (phase_reg)
            trfu_pkg::PH_COUNT: begin
                expected_next = s_rx_byte;
                seen_next     = 8'd0;
                phase_next    = (s_rx_byte == 8'd0) ? trfu_pkg::PH_SKIP : trfu_pkg::PH_TAG;
            end
            trfu_pkg::PH_TAG: begin
                op.clear = 1'b1;
                if (tag_ok) begin
                    tag_next       = s_rx_byte[3:0];
                    remaining_next = trfu_pkg::payload_size(s_rx_byte[3:0]);
                    idx_next       = 3'd0;
                    phase_next     = trfu_pkg::PH_PAYLOAD;
                    op.tag         = s_rx_byte[3:0];
                    if (last) begin
                        op.emit   = 1'b1;
                        op.status = trfu_pkg::STATUS_TRUNCATED;
                        op.last   = 1'b1;
                    end
                end else begin
                    op.emit    = 1'b1;
                    op.tag     = 4'd0;
                    op.status  = trfu_pkg::STATUS_BAD_TAG;
                    op.last    = 1'b1;
                    phase_next = trfu_pkg::PH_SKIP;
                end
            end
            trfu_pkg::PH_PAYLOAD: begin
                op.write       = 1'b1;
                remaining_next = remaining_reg - 4'd1;
                idx_next       = idx_reg + 3'd1;
                if (remaining_reg == 4'd1) begin
                    seen_next  = seen_inc;
                    op.emit    = 1'b1;
                    op.last    = (seen_inc == expected_reg) || last;
                    phase_next = (seen_inc == expected_reg) ?
                                 trfu_pkg::PH_SKIP : trfu_pkg::PH_TAG;
                end else if (last) begin
                    op.emit   = 1'b1;
                    op.status = trfu_pkg::STATUS_TRUNCATED;
                    op.last   = 1'b1;
                end
            end
            trfu_pkg::PH_SKIP: begin
            end
            default: begin
                phase_next = trfu_pkg::PH_SKIP;
            end
        endcase

        if (last) begin
            phase_next = trfu_pkg::PH_COUNT;
            pos_next   = 8'd0;
        end else begin
            pos_next   = pos_reg + 8'd1;
        end
    end

    assign q_push = accept && (op.clear || op.write || op.emit);
    assign q_op   = op;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_length_reg <= trfu_pkg::FRAME_LENGTH_RESET;
        end else if (cfg_wr_en) begin
            frame_length_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= trfu_pkg::PH_COUNT;
            pos_reg       <= 8'd0;
            expected_reg  <= 8'd0;
            seen_reg      <= 8'd0;
            tag_reg       <= 4'd0;
            remaining_reg <= 4'd0;
            idx_reg       <= 3'd0;
        end else if (accept) begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            expected_reg  <= expected_next;
            seen_reg      <= seen_next;
            tag_reg       <= tag_next;
            remaining_reg <= remaining_next;
            idx_reg       <= idx_next;
        end
    end

    `TRFU_ASSERT_SAME(a_error_ends_run,
        q_push && q_op.emit && (q_op.status != trfu_pkg::STATUS_OK), q_op.last,
        "error result without end-of-frame mark")

    `TRFU_ASSERT_SAME(a_frame_wraps,
        accept && last, pos_next == 8'd0 && phase_next == trfu_pkg::PH_COUNT,
        "frame did not restart after its last byte")

endmodule

`default_nettype wire

[hdl/trfu_fifo.sv]
`default_nettype none

`include "typed_record_frame_unpacker_defines.svh"

module trfu_fifo #(
    parameter int DEPTH = trfu_pkg::FIFO_DEPTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  trfu_pkg::op_t      push_op,
    output logic               full,
    input  wire logic          pop,
    output trfu_pkg::op_t      head_op,
    output logic               empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    trfu_pkg::op_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign head_op = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    `TRFU_ASSERT_SAME(a_no_overflow, push, !full || pop, "push into a full queue")
    `TRFU_ASSERT_SAME(a_no_underflow, pop, !empty, "pop from an empty queue")

endmodule

`default_nettype wire

[hdl/trfu_back.sv]
`default_nettype none

`include "typed_record_frame_unpacker_defines.svh"

module trfu_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_empty,
    input  trfu_pkg::op_t      q_op,
    output logic               q_pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [3:0]         m_record_tag,
    output logic [63:0]        m_record_bits,
    output logic [1:0]         m_status,
    output logic               m_frame_last
);

    logic [63:0]       acc_reg, acc_next;
    logic              valid_reg, valid_next;
    logic [3:0]        tag_reg;
    logic [63:0]       bits_reg;
    trfu_pkg::status_t status_reg;
    logic              last_reg;
    logic [63:0]       lane;
    logic              load;

    assign q_pop = !q_empty && (!valid_reg || m_ready);
    assign load  = q_pop && q_op.emit;
    assign lane  = 64'(q_op.data) << {q_op.idx, 3'b000};

    always_comb begin
        acc_next = q_op.clear ? 64'd0 : acc_reg;
        if (q_op.write) begin
            acc_next = acc_next | lane;
        end
        valid_next = valid_reg;
        if (valid_reg && m_ready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            acc_reg   <= 64'd0;
        end else begin
            valid_reg <= valid_next;
            if (q_pop) begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tag_reg    <= q_op.tag;
            bits_reg   <= (q_op.status == trfu_pkg::STATUS_BAD_TAG) ? 64'd0 : acc_next;
            status_reg <= q_op.status;
            last_reg   <= q_op.last;
        end
    end

    assign m_valid       = valid_reg;
    assign m_record_tag  = tag_reg;
    assign m_record_bits = bits_reg;
    assign m_status      = status_reg;
    assign m_frame_last  = last_reg;

    `TRFU_ASSERT_NEXT(a_load_shows, load, valid_reg, "loaded result not presented")
    `TRFU_ASSERT_SAME(a_bad_tag_clean,
        valid_reg && (status_reg == trfu_pkg::STATUS_BAD_TAG),
        tag_reg == 4'd0 && bits_reg == 64'd0,
        "invalid-tag result carries a tag or payload")

endmodule

`default_nettype wire

[hdl/typed_record_frame_unpacker.sv]
// Typed record frame unpacker.
// Input channel (s_valid/s_ready/s_rx_byte): one byte of a received frame per item.
// The first byte of a frame is the record count; each record is a tag byte
// (1..8) followed by 8, 4, 4, 4, 2, 2, 1 or 1 little-endian payload bytes.
// Output channel (m_valid/m_ready/m_*): one item per finished record, per
// invalid tag, or per record cut short by the end of the frame.
// cfg_wr_en/cfg_wr_data write the frame length (bytes per frame) while idle.
// The user must keep to this, as the block does not enforce it. Throughput is
// one byte per cycle while s_ready is high; the parser decides everything about
// a byte in the cycle it is accepted. A result passes from the byte that
// completes it through the queue and then into the output register. When the
// receiver stalls, the held result waits in the output register and the queue
// absorbs up to FIFO_DEPTH further tag, payload or result bytes before s_ready
// drops; bytes that cause no work are always taken while room remains.
// Reset clears the parser to await a count byte, empties the queue and the
// output register, and sets the frame length to 100.
`default_nettype none

module typed_record_frame_unpacker #(
    parameter int FIFO_DEPTH = trfu_pkg::FIFO_DEPTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic [7:0]    cfg_wr_data,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [7:0]    s_rx_byte,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [3:0]         m_record_tag,
    output logic [63:0]        m_record_bits,
    output logic [1:0]         m_status,
    output logic               m_frame_last
);

    // Classified bytes travel from the parser to the assembler through a
    // short queue, so a stalled receiver does not freeze the parser at once.
    trfu_pkg::op_t push_op;
    trfu_pkg::op_t head_op;
    logic          push;
    logic          pop;
    logic          full;
    logic          empty;

    // Front: tracks frame position, record counts and payload progress, and
    // turns each tag and payload byte into an accumulator command.
    trfu_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .q_full      (full),
        .q_push      (push),
        .q_op        (push_op)
    );

    trfu_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_op (push_op),
        .full    (full),
        .pop     (pop),
        .head_op (head_op),
        .empty   (empty)
    );

    // Back: merges payload bytes into the 64-bit value and holds each result
    // in the output register until the receiver takes it.
    trfu_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (empty),
        .q_op          (head_op),
        .q_pop         (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_record_tag  (m_record_tag),
        .m_record_bits (m_record_bits),
        .m_status      (m_status),
        .m_frame_last  (m_frame_last)
    );

endmodule

`default_nettype wire

[sim/testbench.sv]
`default_nettype none

module testbench;

    // Record type tags as they appear on the byte stream. Tag zero is what the
    // block reports in place of a tag when the tag byte was not a known type.
    localparam logic [3:0] TAG_NONE   = 4'd0;
    localparam logic [3:0] TAG_DOUBLE = 4'd1;
    localparam logic [3:0] TAG_FLOAT  = 4'd2;
    localparam logic [3:0] TAG_INT32  = 4'd3;
    localparam logic [3:0] TAG_UINT32 = 4'd4;
    localparam logic [3:0] TAG_INT16  = 4'd5;
    localparam logic [3:0] TAG_UINT16 = 4'd6;
    localparam logic [3:0] TAG_INT8   = 4'd7;
    localparam logic [3:0] TAG_UINT8  = 4'd8;

    // Bytes that the random part sends; together with the directed tests the
    // run offers about 1400 items.
    localparam int RANDOM_ITEMS  = 1150;
    // A result passes through the queue and the output register; this wait leaves
    // a wide margin before the frame length is rewritten or the run is closed.
    localparam int SETTLE_CYCLES = 8;
    // The slowest correct run stays well below this.
    localparam int CYCLE_LIMIT   = 400000;

    // One expected item on the result channel.
    typedef struct {
        logic [3:0]        tag;
        logic [63:0]       bits;
        trfu_pkg::status_t status;
        logic              last;
    } decoded_record_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic [3:0]  m_record_tag;
    logic [63:0] m_record_bits;
    logic [1:0]  m_status;
    logic        m_frame_last;

    typed_record_frame_unpacker dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_record_tag (m_record_tag),
        .m_record_bits(m_record_bits),
        .m_status     (m_status),
        .m_frame_last (m_frame_last)
    );

    // Records that the parser is known to owe, oldest first.
    decoded_record_t pending_records[$];
    // The frame being assembled by the stimulus tasks.
    logic [7:0]      frame_bytes[$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int bytes_sent     = 0;
    // Random idling on both channels is switched off for some stretches.
    bit idle_on        = 1'b1;
    // Set by a test to make the receiver hold m_ready low; the value gives the length of the hold.
    int hold_request   = 0;

    // Shadow copy of the parser state and the frame length register.
    logic [7:0]        pr_frame_len = trfu_pkg::FRAME_LENGTH_RESET;
    trfu_pkg::phase_t  pr_phase     = trfu_pkg::PH_COUNT;
    logic [7:0]        pr_pos       = 8'd0;
    logic [7:0]        pr_expected  = 8'd0;
    logic [7:0]        pr_seen      = 8'd0;
    logic [3:0]        pr_tag       = 4'd0;
    logic [3:0]        pr_left      = 4'd0;
    logic [63:0]       pr_acc       = 64'd0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Run limit: a hang anywhere ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL typed_record_frame_unpacker");
            $finish;
        end
    end

    // Payload length in bytes for each known tag; unknown tags carry nothing.
    function automatic int record_size(input logic [3:0] tg);
        if (tg == TAG_DOUBLE) return 8;
        if (tg >= TAG_FLOAT && tg <= TAG_UINT32) return 4;
        if (tg == TAG_INT16 || tg == TAG_UINT16) return 2;
        if (tg == TAG_INT8 || tg == TAG_UINT8) return 1;
        return 0;
    endfunction

    // Advances the shadow parser by one accepted byte and queues whatever
    // record that byte finishes, reports or cuts short.
    task automatic unpack_byte(input logic [7:0] b);
        int              len;
        int              size;
        bit              at_end;
        bit              done;
        logic [2:0]      lane;
        decoded_record_t rec;
        // Frame lengths below two behave as two.
        len    = (pr_frame_len < trfu_pkg::FRAME_LENGTH_MIN) ?
                 trfu_pkg::FRAME_LENGTH_MIN : pr_frame_len;
        at_end = (pr_pos + 32'd1 >= len);
        bytes_sent++;
        case (pr_phase)
            trfu_pkg::PH_COUNT: begin
                pr_expected = b;
                pr_seen     = 8'd0;
                pr_phase    = (b == 8'd0) ? trfu_pkg::PH_SKIP : trfu_pkg::PH_TAG;
            end
            trfu_pkg::PH_TAG: begin
                if (b >= TAG_DOUBLE && b <= TAG_UINT8) begin
                    pr_tag   = b[3:0];
                    pr_left  = 4'(record_size(b[3:0]));
                    pr_acc   = 64'd0;
                    pr_phase = trfu_pkg::PH_PAYLOAD;
                    // The frame ends right after the tag byte: nothing arrived.
                    if (at_end) begin
                        rec = '{tag: pr_tag, bits: 64'd0,
                                status: trfu_pkg::STATUS_TRUNCATED, last: 1'b1};
                        pending_records.push_back(rec);
                    end
                end else begin
                    rec = '{tag: TAG_NONE, bits: 64'd0,
                            status: trfu_pkg::STATUS_BAD_TAG, last: 1'b1};
                    pending_records.push_back(rec);
                    pr_phase = trfu_pkg::PH_SKIP;
                end
            end
            trfu_pkg::PH_PAYLOAD: begin
                size    = record_size(pr_tag);
                lane    = 3'(size - pr_left);
                pr_acc  = pr_acc | ({56'd0, b} << (8 * lane));
                pr_left = pr_left - 4'd1;
                if (pr_left == 4'd0) begin
                    pr_seen = pr_seen + 8'd1;
                    done    = (pr_seen == pr_expected);
                    rec = '{tag: pr_tag, bits: pr_acc, status: trfu_pkg::STATUS_OK,
                            last: done || at_end};
                    pending_records.push_back(rec);
                    pr_phase = done ? trfu_pkg::PH_SKIP : trfu_pkg::PH_TAG;
                end else if (at_end) begin
                    rec = '{tag: pr_tag, bits: pr_acc,
                            status: trfu_pkg::STATUS_TRUNCATED, last: 1'b1};
                    pending_records.push_back(rec);
                end
            end
            default: ;
        endcase
        // The last byte of a frame always returns the parser to the count byte.
        if (at_end) begin
            pr_phase = trfu_pkg::PH_COUNT;
            pr_pos   = 8'd0;
        end else begin
            pr_pos = pr_pos + 8'd1;
        end
    endtask

    // Result checker: every accepted result is matched against the oldest
    // record still owed.
    always @(posedge aclk) begin : result_check
        decoded_record_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_records.size() == 0) begin
                $error("unexpected result: tag %0d bits %h status %0d last %0d",
                       m_record_tag, m_record_bits, m_status, m_frame_last);
                mismatch_count++;
            end else begin
                want = pending_records.pop_front();
                if (m_record_tag !== want.tag) begin
                    $error("record_tag expected %0d got %0d", want.tag, m_record_tag);
                    mismatch_count++;
                end
                if (m_record_bits !== want.bits) begin
                    $error("record_bits expected %h got %h", want.bits, m_record_bits);
                    mismatch_count++;
                end
                if (m_status !== want.status) begin
                    $error("status expected %0d got %0d", want.status, m_status);
                    mismatch_count++;
                end
                if (m_frame_last !== want.last) begin
                    $error("frame_last expected %0d got %0d", want.last, m_frame_last);
                    mismatch_count++;
                end
            end
        end
    end

    // Receiver: while idling is on it may hold off at random after each taken result,
    // and on request it holds off for a long stretch so the block backs up.
    initial begin : result_receiver
        int stall_left;
        stall_left = 0;
        m_ready    = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end else if (m_valid === 1'b1 && m_ready && idle_on) begin
                stall_left = $urandom_range(0, 4);
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offers one byte, after an optional gap, and returns at the edge where
    // it is taken. Valid is lowered only when a gap follows, so a byte sent
    // straight after the previous one keeps valid high without a glitch.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (s_ready !== 1'b1);
        unpack_byte(b);
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
    endtask

    // Stops offering bytes and waits until every owed record has arrived.
    // It waits on the clock before checking, so valid is never raised in the same step.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_records.size() != 0);
    endtask

    // The frame length is only rewritten with the block drained and settled.
    task automatic set_frame_length(input logic [7:0] len);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        pr_frame_len = len;
    endtask

    // Builds one frame of exactly len bytes. The style picks its shape:
    // 0 to 5 well formed with padding, 6 records running past the frame end,
    // 7 an unknown tag after some records, 8 a count not above the records sent,
    // 9 pure noise.
    task automatic build_frame(input int len, input int style);
        int         nrec;
        int         size;
        int         count;
        logic [3:0] tg;
        frame_bytes.delete();
        if (style == 9) begin
            repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        nrec = 0;
        forever begin
            tg   = 4'($urandom_range(TAG_DOUBLE, TAG_UINT8));
            size = record_size(tg);
            if (style <= 5 || style == 8) begin
                if (frame_bytes.size() + 1 + size > len - 1 || $urandom_range(0, 15) == 0)
                    break;
            end else if (frame_bytes.size() >= len - 1) begin
                break;
            end
            if (style == 7 && $urandom_range(0, 5) == 0) begin
                if ($urandom_range(0, 1) == 0)
                    frame_bytes.push_back({4'd0, TAG_NONE});
                else
                    frame_bytes.push_back(8'($urandom_range(TAG_UINT8 + 1, 255)));
                break;
            end
            frame_bytes.push_back({4'd0, tg});
            repeat (size) frame_bytes.push_back(8'($urandom_range(0, 255)));
            nrec++;
        end
        case (style)
            6:       count = nrec + $urandom_range(0, 2);
            7:       count = nrec + $urandom_range(1, 3);
            8:       count = $urandom_range(0, nrec);
            default: count = nrec;
        endcase
        while (frame_bytes.size() > len - 1) void'(frame_bytes.pop_back());
        while (frame_bytes.size() < len - 1) frame_bytes.push_back(8'($urandom_range(0, 255)));
        frame_bytes.push_front(8'(count));
    endtask

    // Lengths zero and one act as two: an unknown tag, a zero count and a
    // record cut right after its tag byte all fit in such frames.
    task automatic test_short_lengths();
        set_frame_length(8'd0);
        frame_bytes = '{8'd1, 8'd9};
        send_frame();
        frame_bytes = '{8'd1, 8'd255};
        send_frame();
        set_frame_length(8'd1);
        frame_bytes = '{8'd0, 8'd255};
        send_frame();
        frame_bytes = '{8'd3, {4'd0, TAG_UINT8}};
        send_frame();
    endtask

    task automatic test_zero_tag();
        set_frame_length(trfu_pkg::FRAME_LENGTH_MIN);
        frame_bytes = '{8'd1, {4'd0, TAG_NONE}};
        send_frame();
    endtask

    // A double whose payload is cut after four bytes reports those bytes.
    task automatic test_cut_payload();
        set_frame_length(8'd6);
        frame_bytes = '{8'd1, {4'd0, TAG_DOUBLE}, 8'hFF, 8'h00, 8'hA5, 8'h5A};
        send_frame();
    endtask

    // The count promises three records but the frame ends after the second,
    // which completes exactly on the last byte and so closes the frame.
    task automatic test_record_at_frame_end();
        set_frame_length(8'd5);
        frame_bytes = '{8'd3, {4'd0, TAG_INT8}, 8'h80, {4'd0, TAG_UINT8}, 8'h7F};
        send_frame();
    endtask

    // The receiver stops for a long stretch while the sender keeps offering
    // dense records, so the block's queue fills and s_ready must drop.
    task automatic test_receiver_hold();
        set_frame_length(8'd40);
        idle_on      = 1'b0;
        hold_request = 60;
        repeat (3) begin
            build_frame(40, 0);
            send_frame();
        end
        idle_on = 1'b1;
    endtask

    // The sender stops mid-stream until the block has delivered everything.
    task automatic test_sender_pause();
        repeat (2) begin
            build_frame(40, $urandom_range(0, 8));
            send_frame();
            wait_for_results();
        end
    endtask

    // Random phases, each with its own frame length and one to six frames.
    task automatic test_random_frames();
        int         start;
        int         pick;
        int         eff;
        logic [7:0] len;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)      len = 8'd255;
            else if (pick == 1) len = 8'($urandom_range(0, 1));
            else if (pick == 2) len = trfu_pkg::FRAME_LENGTH_RESET;
            else                len = 8'($urandom_range(2, 40));
            set_frame_length(len);
            eff = (len < trfu_pkg::FRAME_LENGTH_MIN) ? trfu_pkg::FRAME_LENGTH_MIN : len;
            repeat ((eff > 60) ? 1 : $urandom_range(2, 6)) begin
                idle_on = ($urandom_range(0, 3) != 0);
                build_frame(eff, $urandom_range(0, 9));
                send_frame();
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 8'd0;
        s_valid     = 1'b0;
        s_rx_byte   = 8'd0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_short_lengths();
        test_zero_tag();
        test_cut_payload();
        test_record_at_frame_end();
        test_receiver_hold();
        test_sender_pause();
        test_random_frames();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASS typed_record_frame_unpacker");
        end else begin
            $display("FAIL typed_record_frame_unpacker");
        end
        $finish;
    end

endmodule

`default_nettype wire
